>>> rtl/ccp_pkg.sv
// shared types and constants for the channel command parser
// no dependencies; used by the top level and the testbench
package ccp_pkg;

  localparam int unsigned PayloadLimitDefault = 256;
  localparam logic [7:0]  MaxChannelReset     = 8'd16;

  localparam logic [7:0] ChTypePing   = 8'h50;  // 'P'
  localparam logic [7:0] ChTypeSub    = 8'h53;  // 'S'
  localparam logic [7:0] ChTypeXfer   = 8'h54;  // 'T'
  localparam logic [7:0] ChTypeGet    = 8'h47;  // 'G'
  localparam logic [7:0] ChColon      = 8'h3a;  // ':'
  localparam logic [7:0] ChSemi       = 8'h3b;  // ';'
  localparam logic [7:0] ChZeroDigit  = 8'h30;  // '0'
  localparam logic [7:0] ChNineDigit  = 8'h39;  // '9'

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_CHANNEL,
    PH_PAYLOAD,
    PH_SKIP
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_WRONG_TYPE     = 3'd1,
    ST_UNEXPECTED_END = 3'd2,
    ST_BAD_FORMAT     = 3'd3,
    ST_ZERO_BYTE      = 3'd4,
    ST_NO_TERMINATOR  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    KIND_ACTIVATE  = 3'd0,
    KIND_PING      = 3'd1,
    KIND_SUBSCRIBE = 3'd2,
    KIND_TRANSFER  = 3'd3,
    KIND_GET       = 3'd4
  } kind_t;

  // adds one decimal digit to the channel, saturating at max plus one
  function automatic logic [8:0] add_digit(input logic [8:0] acc,
                                           input logic [7:0] b,
                                           input logic [7:0] max_ch);
    logic [11:0] v;
    logic [8:0]  cap;
    v   = ({3'b000, acc} << 3) + ({3'b000, acc} << 1) + {8'h00, b[3:0]};
    cap = {1'b0, max_ch} + 9'd1;
    return (v > {3'b000, cap}) ? cap : v[8:0];
  endfunction

endpackage

>>> rtl/ccp_in_if.sv
// input channel of the channel command parser: one buffer byte per item
// depends on nothing
interface ccp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_in_buffer;

  modport source (output valid, output in_byte, output last_in_buffer, input ready);
  modport sink   (input valid, input in_byte, input last_in_buffer, output ready);
endinterface

>>> rtl/ccp_out_if.sv
// result channel of the channel command parser
// depends on nothing
interface ccp_out_if;
  logic       valid;
  logic       ready;
  logic       data_valid;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic       done_res;
  logic [2:0] status;
  logic [2:0] command_type;
  logic [8:0] channel;

  modport source (output valid, output data_valid, output payload_byte,
                  output payload_index, output done_res, output status,
                  output command_type, output channel, input ready);
  modport sink   (input valid, input data_valid, input payload_byte,
                  input payload_index, input done_res, input status,
                  input command_type, input channel, output ready);
endinterface

>>> rtl/channel_command_parser.sv
// channel command parser, top level
// depends on ccp_pkg, ccp_in_if and ccp_out_if
//
// usage:
//   bytes   - one command buffer byte per item, last_in_buffer on the final byte
//   result  - at most one result item per byte: a captured payload byte with
//             its index, and/or the final status of the buffer
//   cfg_we / cfg_wdata - write max_channel, only while idle
// throughput: one byte per cycle unless the result register is held; the parse of a byte
//   is a single pass of decode and a multiply-by-ten digit add ahead of the result register
// a result is registered and appears in the cycle after its byte is accepted
// bytes that give no result (non-final channel digits and in-range ':', a non-final type
//   byte of a non activate command, bytes after the final status) leave no trace on result
// stall: the result register holds while result.ready is low; a new byte is
//   still taken when the register is empty or is being drained that cycle
// reset: rst is synchronous; the parser waits for a type byte, max_channel
//   returns to 16 and the result register is emptied
module channel_command_parser #(
  parameter int unsigned PAYLOAD_LIMIT = ccp_pkg::PayloadLimitDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  ccp_in_if.sink      bytes,
  ccp_out_if.source   result
);

  localparam logic [8:0] LimitIndex = 9'(PAYLOAD_LIMIT - 1);

  logic [7:0]      max_channel;
  ccp_pkg::phase_t phase, phase_next;
  logic [2:0]      kind, kind_next;
  logic [8:0]      channel_acc, channel_acc_next;
  logic [7:0]      payload_count, payload_count_next;

  logic            res_emit;
  logic            res_data_valid;
  logic [7:0]      res_byte;
  logic [7:0]      res_index;
  logic            res_done;
  logic [2:0]      res_status;

  logic            out_valid;
  logic            accept;

  logic [7:0] b;
  logic       last;
  logic       is_digit;
  logic       at_limit;
  logic [8:0] digit_sum;

  assign b        = bytes.in_byte;
  assign last     = bytes.last_in_buffer;
  assign is_digit = (b >= ccp_pkg::ChZeroDigit) && (b <= ccp_pkg::ChNineDigit);
  // the type byte starts a fresh channel
  assign digit_sum = ccp_pkg::add_digit((phase == ccp_pkg::PH_TYPE) ? 9'd0 : channel_acc,
                                        b, max_channel);
  assign at_limit  = ({1'b0, payload_count} + 9'd1) >= LimitIndex;

  assign bytes.ready = !out_valid || result.ready;
  assign accept      = bytes.valid && bytes.ready;

  // next state
  always_comb begin
    phase_next         = phase;
    kind_next          = kind;
    channel_acc_next   = channel_acc;
    payload_count_next = payload_count;
    case (phase)
      ccp_pkg::PH_TYPE: begin
        payload_count_next = 8'd0;
        channel_acc_next   = is_digit ? digit_sum : 9'd0;
        if (is_digit) begin
          kind_next = ccp_pkg::KIND_ACTIVATE;
        end else if (b == ccp_pkg::ChTypePing) begin
          kind_next = ccp_pkg::KIND_PING;
        end else if (b == ccp_pkg::ChTypeSub) begin
          kind_next = ccp_pkg::KIND_SUBSCRIBE;
        end else if (b == ccp_pkg::ChTypeXfer) begin
          kind_next = ccp_pkg::KIND_TRANSFER;
        end else if (b == ccp_pkg::ChTypeGet) begin
          kind_next = ccp_pkg::KIND_GET;
        end else begin
          kind_next = ccp_pkg::KIND_ACTIVATE;
        end
        if (last) begin
          phase_next = ccp_pkg::PH_TYPE;
        end else if (is_digit || b == ccp_pkg::ChTypePing || b == ccp_pkg::ChTypeSub ||
                     b == ccp_pkg::ChTypeXfer || b == ccp_pkg::ChTypeGet) begin
          phase_next = ccp_pkg::PH_CHANNEL;
        end else begin
          phase_next = ccp_pkg::PH_SKIP;
        end
      end
      ccp_pkg::PH_CHANNEL: begin
        if (is_digit) begin
          channel_acc_next = digit_sum;
          phase_next       = last ? ccp_pkg::PH_TYPE : ccp_pkg::PH_CHANNEL;
        end else if (b == ccp_pkg::ChColon && channel_acc <= {1'b0, max_channel} && !last) begin
          phase_next = ccp_pkg::PH_PAYLOAD;
        end else begin
          phase_next = last ? ccp_pkg::PH_TYPE : ccp_pkg::PH_SKIP;
        end
      end
      ccp_pkg::PH_PAYLOAD: begin
        if (last) begin
          phase_next = ccp_pkg::PH_TYPE;
        end else if (b == ccp_pkg::ChSemi || b == 8'd0) begin
          phase_next = ccp_pkg::PH_SKIP;
        end else begin
          payload_count_next = payload_count + 8'd1;
          phase_next         = at_limit ? ccp_pkg::PH_SKIP : ccp_pkg::PH_PAYLOAD;
        end
      end
      ccp_pkg::PH_SKIP: begin
        if (last) begin
          phase_next = ccp_pkg::PH_TYPE;
        end
      end
      default: begin
        phase_next = ccp_pkg::PH_TYPE;
      end
    endcase
  end

  // result of the current byte
  always_comb begin
    res_emit       = 1'b0;
    res_data_valid = 1'b0;
    res_byte       = 8'd0;
    res_index      = 8'd0;
    res_done       = 1'b0;
    res_status     = ccp_pkg::ST_OK;
    case (phase)
      ccp_pkg::PH_TYPE: begin
        if (!(is_digit || b == ccp_pkg::ChTypePing || b == ccp_pkg::ChTypeSub ||
              b == ccp_pkg::ChTypeXfer || b == ccp_pkg::ChTypeGet)) begin
          res_emit   = 1'b1;
          res_done   = 1'b1;
          res_status = ccp_pkg::ST_WRONG_TYPE;
        end else if (last) begin
          res_emit   = 1'b1;
          res_done   = 1'b1;
          res_status = ccp_pkg::ST_UNEXPECTED_END;
        end
      end
      ccp_pkg::PH_CHANNEL: begin
        if (is_digit) begin
          if (last) begin
            res_emit   = 1'b1;
            res_done   = 1'b1;
            res_status = ccp_pkg::ST_UNEXPECTED_END;
          end
        end else if (channel_acc > {1'b0, max_channel} || b != ccp_pkg::ChColon) begin
          res_emit   = 1'b1;
          res_done   = 1'b1;
          res_status = ccp_pkg::ST_BAD_FORMAT;
        end else if (last) begin
          res_emit   = 1'b1;
          res_done   = 1'b1;
          res_status = ccp_pkg::ST_NO_TERMINATOR;
        end
      end
      ccp_pkg::PH_PAYLOAD: begin
        res_emit = 1'b1;
        if (last) begin
          res_done   = 1'b1;
          res_status = ccp_pkg::ST_NO_TERMINATOR;
        end else if (b == 8'd0) begin
          res_done   = 1'b1;
          res_status = ccp_pkg::ST_ZERO_BYTE;
        end else begin
          res_data_valid = 1'b1;
          res_byte       = b;
          res_index      = payload_count;
          if (b == ccp_pkg::ChSemi) begin
            res_done = 1'b1;
          end else if (at_limit) begin
            res_done   = 1'b1;
            res_status = ccp_pkg::ST_NO_TERMINATOR;
          end
        end
      end
      default: begin
        res_emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_channel   <= ccp_pkg::MaxChannelReset;
      phase         <= ccp_pkg::PH_TYPE;
      kind          <= 3'd0;
      channel_acc   <= 9'd0;
      payload_count <= 8'd0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_channel <= cfg_wdata;
      end
      if (accept) begin
        phase         <= phase_next;
        kind          <= kind_next;
        channel_acc   <= channel_acc_next;
        payload_count <= payload_count_next;
        out_valid     <= res_emit;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload side of the result register
  always_ff @(posedge clk) begin
    if (accept && res_emit) begin
      result.data_valid    <= res_data_valid;
      result.payload_byte  <= res_byte;
      result.payload_index <= res_index;
      result.done_res      <= res_done;
      result.status        <= res_status;
      result.command_type  <= kind_next;
      result.channel       <= channel_acc_next;
    end
  end

  assign result.valid = out_valid;

endmodule

>>> sim/channel_command_parser_tb.sv
// testbench for channel_command_parser: directed command buffers, then random ones
// checked item by item against a parser predictor; needs ccp_pkg, ccp_in_if, ccp_out_if
`timescale 1ns / 1ps

module channel_command_parser_tb;
  import ccp_pkg::*;

  localparam int unsigned PayloadLimit  = PayloadLimitDefault;
  localparam int unsigned HoldCycles    = 200;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned EndLimit      = 1000;
  localparam int unsigned PhaseItems    = 250;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_TYPED} row_check_t;

  typedef struct packed {
    logic       dv;
    logic [7:0] pbyte;
    logic [7:0] pidx;
    logic       done;
    status_t    st;
    kind_t      kind;
    logic [8:0] chan;
  } parse_result_t;

  typedef struct {
    logic [7:0] b;
    bit         last;
    row_check_t chk;
    status_t    st;
    kind_t      kind;
    logic [8:0] chan;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  ccp_in_if  bytes_if ();
  ccp_out_if result_if ();

  channel_command_parser dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .bytes     (bytes_if),
    .result    (result_if)
  );

  // parser state as the predictor tracks it
  phase_t     p_phase;
  kind_t      p_kind;
  logic [8:0] p_chan;
  logic [7:0] p_count;
  logic [7:0] p_max;

  parse_result_t pending_results[$];
  int unsigned   errors       = 0;
  int unsigned   cmd_items    = 0;
  int unsigned   stall_cycles = 0;
  bit            steady       = 1'b0;
  bit            hold_request = 1'b0;

  // max_channel is 16 out of reset
  dir_row_t dir_rows [0:27] = '{
    '{"X",         1'b1, ROW_TYPED,   ST_WRONG_TYPE,     KIND_ACTIVATE,  9'd0},
    '{8'h00,       1'b0, ROW_TYPED,   ST_WRONG_TYPE,     KIND_ACTIVATE,  9'd0},
    '{8'hff,       1'b1, ROW_SILENT,  ST_OK,             KIND_ACTIVATE,  9'd0},
    '{ChTypePing,  1'b1, ROW_TYPED,   ST_UNEXPECTED_END, KIND_PING,      9'd0},
    '{"9",         1'b1, ROW_TYPED,   ST_UNEXPECTED_END, KIND_ACTIVATE,  9'd9},
    '{ChTypeSub,   1'b0, ROW_SILENT,  ST_OK,             KIND_ACTIVATE,  9'd0},
    '{"1",         1'b0, ROW_SILENT,  ST_OK,             KIND_ACTIVATE,  9'd0},
    '{"7",         1'b0, ROW_SILENT,  ST_OK,             KIND_ACTIVATE,  9'd0},
    '{ChColon,     1'b1, ROW_TYPED,   ST_BAD_FORMAT,     KIND_SUBSCRIBE, 9'd17},
    '{ChTypeXfer,  1'b0, ROW_SILENT,  ST_OK,             KIND_ACTIVATE,  9'd0},
    '{"1",         1'b0, ROW_SILENT,  ST_OK,             KIND_ACTIVATE,  9'd0},
    '{"6",         1'b0, ROW_SILENT,  ST_OK,             KIND_ACTIVATE,  9'd0},
    '{ChColon,     1'b0, ROW_SILENT,  ST_OK,             KIND_ACTIVATE,  9'd0},
    '{8'hff,       1'b0, ROW_PREDICT, ST_OK,             KIND_ACTIVATE,  9'd0},
    '{8'h01,       1'b0, ROW_PREDICT, ST_OK,             KIND_ACTIVATE,  9'd0},
    '{ChSemi,      1'b0, ROW_PREDICT, ST_OK,             KIND_ACTIVATE,  9'd0},
    '{"z",         1'b1, ROW_SILENT,  ST_OK,             KIND_ACTIVATE,  9'd0},
    '{ChTypeGet,   1'b0, ROW_SILENT,  ST_OK,             KIND_ACTIVATE,  9'd0},
    '{"A",         1'b1, ROW_TYPED,   ST_BAD_FORMAT,     KIND_GET,       9'd0},
    '{"2",         1'b0, ROW_SILENT,  ST_OK,             KIND_ACTIVATE,  9'd0},
    '{ChColon,     1'b0, ROW_SILENT,  ST_OK,             KIND_ACTIVATE,  9'd0},
    '{8'h00,       1'b0, ROW_TYPED,   ST_ZERO_BYTE,      KIND_ACTIVATE,  9'd2},
    '{"q",         1'b1, ROW_SILENT,  ST_OK,             KIND_ACTIVATE,  9'd0},
    '{"5",         1'b0, ROW_SILENT,  ST_OK,             KIND_ACTIVATE,  9'd0},
    '{ChColon,     1'b1, ROW_TYPED,   ST_NO_TERMINATOR,  KIND_ACTIVATE,  9'd5},
    '{ChTypePing,  1'b0, ROW_SILENT,  ST_OK,             KIND_ACTIVATE,  9'd0},
    '{ChColon,     1'b0, ROW_SILENT,  ST_OK,             KIND_ACTIVATE,  9'd0},
    '{"a",         1'b1, ROW_TYPED,   ST_NO_TERMINATOR,  KIND_PING,      9'd0}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit is_digit(logic [7:0] b);
    return b >= ChZeroDigit && b <= ChNineDigit;
  endfunction

  // channel times ten plus the digit, held at one above the largest channel
  function automatic logic [8:0] chan_step(logic [8:0] acc, logic [7:0] b);
    int unsigned v;
    int unsigned cap;
    v   = 32'(acc) * 10 + 32'(b - ChZeroDigit);
    cap = 32'(p_max) + 1;
    return (v > cap) ? 9'(cap) : 9'(v);
  endfunction

  function automatic parse_result_t make_result(bit dv, logic [7:0] pb, logic [7:0] idx,
                                                bit done, status_t st);
    parse_result_t r;
    r       = '0;
    r.dv    = dv;
    r.pbyte = pb;
    r.pidx  = idx;
    r.done  = done;
    r.st    = st;
    r.kind  = p_kind;
    r.chan  = p_chan;
    return r;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input bit last, output bit has,
                            output parse_result_t r);
    logic [7:0] idx;
    has = 1'b0;
    r   = '0;
    case (p_phase)
      PH_TYPE: begin
        p_kind  = KIND_ACTIVATE;
        p_chan  = '0;
        p_count = '0;
        if (is_digit(b)) p_chan = chan_step(p_chan, b);
        else if (b == ChTypePing) p_kind = KIND_PING;
        else if (b == ChTypeSub)  p_kind = KIND_SUBSCRIBE;
        else if (b == ChTypeXfer) p_kind = KIND_TRANSFER;
        else if (b == ChTypeGet)  p_kind = KIND_GET;
        else begin
          has = 1'b1;
          r   = make_result(1'b0, '0, '0, 1'b1, ST_WRONG_TYPE);
        end
        if (!has) begin
          if (last) begin
            has = 1'b1;
            r   = make_result(1'b0, '0, '0, 1'b1, ST_UNEXPECTED_END);
          end else begin
            p_phase = PH_CHANNEL;
          end
        end
      end
      PH_CHANNEL: begin
        if (is_digit(b)) begin
          p_chan = chan_step(p_chan, b);
          if (last) begin
            has = 1'b1;
            r   = make_result(1'b0, '0, '0, 1'b1, ST_UNEXPECTED_END);
          end
        end else if (p_chan > {1'b0, p_max} || b != ChColon) begin
          has = 1'b1;
          r   = make_result(1'b0, '0, '0, 1'b1, ST_BAD_FORMAT);
        end else if (last) begin
          has = 1'b1;
          r   = make_result(1'b0, '0, '0, 1'b1, ST_NO_TERMINATOR);
        end else begin
          p_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        idx = p_count;
        has = 1'b1;
        if (last) r = make_result(1'b0, '0, '0, 1'b1, ST_NO_TERMINATOR);
        else if (b == ChSemi) r = make_result(1'b1, b, idx, 1'b1, ST_OK);
        else if (b == 8'h00) r = make_result(1'b0, '0, '0, 1'b1, ST_ZERO_BYTE);
        else begin
          p_count = p_count + 8'd1;
          // the byte that reaches the payload limit closes the command
          if (32'(idx) + 1 >= PayloadLimit - 1)
            r = make_result(1'b1, b, idx, 1'b1, ST_NO_TERMINATOR);
          else
            r = make_result(1'b1, b, idx, 1'b0, ST_OK);
        end
      end
      default: begin
        if (last) p_phase = PH_TYPE;
      end
    endcase
    if (has && r.done) p_phase = last ? PH_TYPE : PH_SKIP;
  endtask

  task automatic send_byte(input logic [7:0] b, input bit last, input row_check_t chk,
                           input parse_result_t typed);
    bit            has;
    parse_result_t r;
    while (!steady && $urandom_range(99) < 31) begin
      bytes_if.valid <= 1'b0;
      @(posedge clk);
    end
    bytes_if.valid          <= 1'b1;
    bytes_if.in_byte        <= b;
    bytes_if.last_in_buffer <= last;
    do @(posedge clk); while (bytes_if.ready !== 1'b1);
    cmd_items++;
    parse_byte(b, last, has, r);
    if (chk == ROW_TYPED) pending_results.push_back(typed);
    else if (chk == ROW_PREDICT && has) pending_results.push_back(r);
  endtask

  // force_len >= 0 gives an intact command of that many payload bytes; channel may be too big
  task automatic send_command(input int force_len);
    logic [7:0] cmd[$];
    string      digits;
    int         mode;
    int         plen;
    int         sel;
    int         j;
    int unsigned n;
    logic [7:0] pb;
    mode = (force_len >= 0) ? 0 : $urandom_range(99);
    if (mode < 85) begin
      sel = $urandom_range(4);
      case ($urandom_range(5))
        0:       n = p_max;
        1:       n = 32'(p_max) + 1;
        2:       n = $urandom_range(p_max);
        3:       n = $urandom_range(999);
        4:       n = $urandom_range(99999);
        default: n = 0;
      endcase
      digits = $sformatf("%0d", n);
      if ($urandom_range(3) == 0) digits = {"0", digits};
      if (sel == 0) begin
        for (int i = 0; i < digits.len(); i++) cmd.push_back(digits[i]);
      end else begin
        case (sel)
          1:       cmd.push_back(ChTypePing);
          2:       cmd.push_back(ChTypeSub);
          3:       cmd.push_back(ChTypeXfer);
          default: cmd.push_back(ChTypeGet);
        endcase
        if ($urandom_range(3) != 0)
          for (int i = 0; i < digits.len(); i++) cmd.push_back(digits[i]);
      end
      cmd.push_back(ChColon);
      if (force_len >= 0) plen = force_len;
      else if ($urandom_range(49) == 0) plen = $urandom_range(258, 250);
      else plen = $urandom_range(12);
      for (int i = 0; i < plen; i++) begin
        pb = 8'($urandom_range(255, 1));
        if (pb == ChSemi) pb = 8'h3c;
        if (force_len < 0 && $urandom_range(39) == 0) pb = 8'h00;
        cmd.push_back(pb);
      end
      if (force_len >= 0 || $urandom_range(9) != 0) cmd.push_back(ChSemi);
      repeat ($urandom_range(2)) cmd.push_back(8'($urandom_range(255)));
      // broken commands: cut short or one byte overwritten
      if (mode >= 70) begin
        j = $urandom_range(cmd.size() - 1);
        if ($urandom_range(1)) cmd = cmd[0:j];
        else cmd[j] = 8'($urandom_range(255));
      end
    end else begin
      repeat ($urandom_range(8, 1)) cmd.push_back(8'($urandom_range(255)));
    end
    foreach (cmd[i]) send_byte(cmd[i], i == cmd.size() - 1, ROW_PREDICT, '0);
  endtask

  task automatic set_max_channel(input logic [7:0] v);
    bytes_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    p_max = v;
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  task automatic check_result();
    parse_result_t want;
    if (pending_results.size() == 0) begin
      $error("result item with nothing expected: status %0d, byte %0d",
             result_if.status, result_if.payload_byte);
      errors++;
    end else begin
      want = pending_results.pop_front();
      check_field("data_valid", want.dv, result_if.data_valid);
      check_field("payload_byte", want.pbyte, result_if.payload_byte);
      check_field("payload_index", want.pidx, result_if.payload_index);
      check_field("done_res", want.done, result_if.done_res);
      check_field("status", want.st, result_if.status);
      check_field("command_type", want.kind, result_if.command_type);
      check_field("channel", want.chan, result_if.channel);
    end
  endtask

  // result side: random ready (always ready in the steady phase), one long hold-off on request
  initial begin
    result_if.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        result_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      result_if.ready <= steady || ($urandom_range(99) >= 31);
      @(posedge clk);
      if (result_if.valid === 1'b1 && result_if.ready === 1'b1) check_result();
    end
  end

  always @(posedge clk) begin
    if (rst || (bytes_if.valid && bytes_if.ready) || (result_if.valid && result_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WatchdogLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0]    settings [0:7];
    parse_result_t typed;
    int unsigned   start;
    int unsigned   guard;
    settings = '{8'd0, 8'd255, 8'd1, 8'd99, 8'd0, MaxChannelReset, 8'd0, 8'd255};
    rst                     <= 1'b1;
    cfg_we                  <= 1'b0;
    cfg_wdata               <= '0;
    bytes_if.valid          <= 1'b0;
    bytes_if.in_byte        <= '0;
    bytes_if.last_in_buffer <= 1'b0;
    p_phase = PH_TYPE;
    p_kind  = KIND_ACTIVATE;
    p_chan  = '0;
    p_count = '0;
    p_max   = MaxChannelReset;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      typed      = '0;
      typed.done = 1'b1;
      typed.st   = dir_rows[i].st;
      typed.kind = dir_rows[i].kind;
      typed.chan = dir_rows[i].chan;
      send_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].chk, typed);
    end

    for (int k = 0; k < 8; k++) begin
      if (k == 4 || k == 6) set_max_channel(8'($urandom_range(255)));
      else set_max_channel(settings[k]);
      steady = (k == 3);
      if (k == 1) begin
        // result side holds off while a long command keeps coming
        hold_request = 1'b1;
        send_command(60);
      end
      start = cmd_items;
      while (cmd_items - start < PhaseItems) send_command(-1);
    end

    bytes_if.valid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < EndLimit) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected result items never arrived", pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
